[rtl/core/mq_pkg.sv]
// Package for the multi-queue replacement policy block.
// Holds sizes, status and register codes, and shared types.
// Depends on nothing; every other file but mq_ram imports it.
`default_nettype none

package mq_pkg;

    localparam int NUM_QUEUES  = 5;
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_SLOTS   = NUM_QUEUES * QUEUE_DEPTH;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int QIDX_W = $clog2(NUM_QUEUES);
    localparam int QCNT_W = $clog2(NUM_QUEUES + 1);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int KEY_W    = 32;
    localparam int USE_W    = 16;
    localparam int TIME_W   = 32;
    localparam int LIFE_W   = 16;
    localparam int LIMIT_W  = 5;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'd1;

    localparam logic [LIFE_W-1:0]  LIFETIME_RESET = 16'd5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 5'd16;

    localparam logic [0:0] OP_ACCESS = 1'b0;
    localparam logic [0:0] OP_INSERT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [USE_W-1:0]  use_cnt;
        logic [TIME_W-1:0] expiry;
    } slot_data_t;

    localparam int DATA_W = $bits(slot_data_t);

    typedef struct packed {
        logic [LIFE_W-1:0]  lifetime;
        logic [LIMIT_W-1:0] queue_limit;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [LEVEL_W-1:0]  level;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [SLOT_W-1:0] raddr;
        logic              data_we;
        logic [SLOT_W-1:0] data_waddr;
        slot_data_t        data_wdata;
        logic              link_we;
        logic [SLOT_W-1:0] link_waddr;
        logic [SLOT_W-1:0] link_wdata;
    } mem_req_t;

endpackage

`default_nettype wire

[rtl/core/mq_req_if.sv]
// Request channel interface: valid/ready with opcode and key.
// Depends on mq_pkg.
`default_nettype none

interface mq_req_if
    import mq_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] req_key;

    modport source (output valid, output opcode, output req_key, input ready);
    modport sink   (input valid, input opcode, input req_key, output ready);
endinterface

`default_nettype wire

[rtl/core/mq_res_if.sv]
// Result channel interface: valid/ready with status, key, level and last.
// Depends on mq_pkg.
`default_nettype none

interface mq_res_if
    import mq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    res_key;
    logic [LEVEL_W-1:0]  level;
    logic                last;

    modport source (output valid, output status, output res_key, output level,
                    output last, input ready);
    modport sink   (input valid, input status, input res_key, input level,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/core/mq_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Depends on mq_pkg.
`default_nettype none

interface mq_cfg_if
    import mq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/mq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module mq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

[rtl/core/mq_engine.sv]
// Sequencer of the multi-queue policy: list walk, unlink, free-slot scan, eviction,
// promotion and aging over the slot memories, plus the result register.
// Depends on mq_pkg and the channel interfaces.
`default_nettype none

module mq_engine
    import mq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    mq_req_if.sink            req,
    mq_res_if.source          res,
    input  wire cfg_t         cfg,
    output mem_req_t          mem,
    input  wire slot_data_t   data_rd,
    input  wire logic [SLOT_W-1:0] link_rd
);
    typedef enum logic [4:0] {
        S_IDLE, S_LK_Q, S_LK_RD, S_LK_CHK, S_DECIDE, S_HIT, S_MR_CHK, S_MR_POP,
        S_EMIT, S_FS_SCAN, S_LINK, S_AG_START, S_AG_RD, S_AG_CHK, S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        M_INS, M_PROMO, M_STAY, M_AGE
    } mode_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic                op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [QCNT_W-1:0]   lk_q_reg, lk_q_next;
    logic [SLOT_W-1:0]   lk_s_reg, lk_s_next;
    logic [SLOT_W-1:0]   lk_prev_reg, lk_prev_next;
    logic [CNT_W-1:0]    lk_k_reg, lk_k_next;
    logic                lk_hasprev_reg, lk_hasprev_next;
    logic                found_reg, found_next;
    logic [QIDX_W-1:0]   f_q_reg, f_q_next;
    logic [SLOT_W-1:0]   f_s_reg, f_s_next;
    logic [SLOT_W-1:0]   f_prev_reg, f_prev_next;
    logic                f_hasprev_reg, f_hasprev_next;
    logic [SLOT_W-1:0]   f_link_reg, f_link_next;
    slot_data_t          f_data_reg, f_data_next;
    logic [USE_W-1:0]    use_new_reg, use_new_next;
    logic [QIDX_W-1:0]   mr_q_reg, mr_q_next;
    logic [QIDX_W-1:0]   lt_q_reg, lt_q_next;
    logic [SLOT_W-1:0]   lt_s_reg, lt_s_next;
    logic [QCNT_W-1:0]   ag_i_reg, ag_i_next;
    logic [SLOT_W-1:0]   fs_idx_reg, fs_idx_next;
    result_t             pend_reg, pend_next;
    result_t             em_reg, em_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   head_reg [NUM_QUEUES];
    logic [SLOT_W-1:0]   head_next [NUM_QUEUES];
    logic [SLOT_W-1:0]   tail_reg [NUM_QUEUES];
    logic [SLOT_W-1:0]   tail_next [NUM_QUEUES];
    logic [CNT_W-1:0]    cnt_reg [NUM_QUEUES];
    logic [CNT_W-1:0]    cnt_next [NUM_QUEUES];
    logic [NUM_SLOTS-1:0] free_reg, free_next;
    logic [TIME_W-1:0]   now_reg, now_next;

    logic [CNT_W-1:0]    eff_limit;
    logic                out_free;
    logic [TIME_W-1:0]   fresh_expiry;
    logic                promote;
    logic [QIDX_W-1:0]   dest_q;
    logic [QIDX_W-1:0]   lk_qi;
    logic [QIDX_W-1:0]   ag_qi;

    // A limit of zero behaves as one; anything above the queue depth is clamped.
    always_comb
    begin
        if (cfg.queue_limit == '0)
        begin
            eff_limit = CNT_W'(1);
        end
        else if (int'(cfg.queue_limit) > QUEUE_DEPTH)
        begin
            eff_limit = CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            eff_limit = CNT_W'(cfg.queue_limit);
        end
    end

    assign out_free     = !out_valid_reg || res.ready;
    assign fresh_expiry = now_reg + TIME_W'(cfg.lifetime);
    assign promote      = {1'b0, use_new_reg} > ((USE_W + 1)'(1) << f_q_reg);
    assign dest_q       = (int'(f_q_reg) < NUM_QUEUES - 1) ? f_q_reg + QIDX_W'(1)
                                                            : f_q_reg;
    assign lk_qi        = lk_q_reg[QIDX_W-1:0];
    assign ag_qi        = ag_i_reg[QIDX_W-1:0];

    assign req.ready   = (state_reg == S_IDLE);
    assign res.valid   = out_valid_reg;
    assign res.status  = out_reg.status;
    assign res.res_key = out_reg.key;
    assign res.level   = out_reg.level;
    assign res.last    = out_reg.last;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        lk_q_next       = lk_q_reg;
        lk_s_next       = lk_s_reg;
        lk_prev_next    = lk_prev_reg;
        lk_k_next       = lk_k_reg;
        lk_hasprev_next = lk_hasprev_reg;
        found_next      = found_reg;
        f_q_next        = f_q_reg;
        f_s_next        = f_s_reg;
        f_prev_next     = f_prev_reg;
        f_hasprev_next  = f_hasprev_reg;
        f_link_next     = f_link_reg;
        f_data_next     = f_data_reg;
        use_new_next    = use_new_reg;
        mr_q_next       = mr_q_reg;
        lt_q_next       = lt_q_reg;
        lt_s_next       = lt_s_reg;
        ag_i_next       = ag_i_reg;
        fs_idx_next     = fs_idx_reg;
        pend_next       = pend_reg;
        em_next         = em_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        free_next       = free_reg;
        now_next        = now_reg;

        mem = '0;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    key_next   = req.req_key;
                    lk_q_next  = '0;
                    found_next = 1'b0;
                    state_next = S_LK_Q;
                end
            end

            // Pick the next non-empty queue to walk.
            S_LK_Q:
            begin
                if (int'(lk_q_reg) >= NUM_QUEUES)
                begin
                    state_next = S_DECIDE;
                end
                else if (cnt_reg[lk_qi] == '0)
                begin
                    lk_q_next = lk_q_reg + QCNT_W'(1);
                end
                else
                begin
                    lk_s_next       = head_reg[lk_qi];
                    lk_k_next       = '0;
                    lk_hasprev_next = 1'b0;
                    lk_prev_next    = '0;
                    state_next      = S_LK_RD;
                end
            end

            S_LK_RD:
            begin
                mem.raddr  = lk_s_reg;
                state_next = S_LK_CHK;
            end

            S_LK_CHK:
            begin
                if (data_rd.key == key_reg)
                begin
                    found_next     = 1'b1;
                    f_q_next       = lk_qi;
                    f_s_next       = lk_s_reg;
                    f_prev_next    = lk_prev_reg;
                    f_hasprev_next = lk_hasprev_reg;
                    f_link_next    = link_rd;
                    f_data_next    = data_rd;
                    state_next     = S_DECIDE;
                end
                else
                begin
                    lk_prev_next    = lk_s_reg;
                    lk_s_next       = link_rd;
                    lk_hasprev_next = 1'b1;
                    lk_k_next       = lk_k_reg + CNT_W'(1);
                    if (lk_k_reg + CNT_W'(1) >= cnt_reg[lk_qi])
                    begin
                        lk_q_next  = lk_q_reg + QCNT_W'(1);
                        state_next = S_LK_Q;
                    end
                    else
                    begin
                        state_next = S_LK_RD;
                    end
                end
            end

            S_DECIDE:
            begin
                pend_next.key  = key_reg;
                pend_next.last = 1'b0;
                if (op_reg == OP_INSERT)
                begin
                    if (found_reg)
                    begin
                        pend_next.status = ST_DUP;
                        pend_next.level  = LEVEL_W'(f_q_reg);
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        pend_next.status = ST_INSERTED;
                        pend_next.level  = '0;
                        mode_next        = M_INS;
                        mr_q_next        = '0;
                        fs_idx_next      = '0;
                        state_next       = S_MR_CHK;
                    end
                end
                else if (!found_reg)
                begin
                    pend_next.status = ST_MISS;
                    pend_next.level  = '0;
                    state_next       = S_FINISH;
                end
                else
                begin
                    // Take the hit entry out of its list.
                    if (!f_hasprev_reg)
                    begin
                        head_next[f_q_reg] = f_link_reg;
                    end
                    else
                    begin
                        mem.link_we    = 1'b1;
                        mem.link_waddr = f_prev_reg;
                        mem.link_wdata = f_link_reg;
                    end
                    if (tail_reg[f_q_reg] == f_s_reg && f_hasprev_reg)
                    begin
                        tail_next[f_q_reg] = f_prev_reg;
                    end
                    cnt_next[f_q_reg] = cnt_reg[f_q_reg] - CNT_W'(1);
                    use_new_next = (f_data_reg.use_cnt == '1) ? f_data_reg.use_cnt
                                                              : f_data_reg.use_cnt + USE_W'(1);
                    state_next = S_HIT;
                end
            end

            S_HIT:
            begin
                mem.data_we            = 1'b1;
                mem.data_waddr         = f_s_reg;
                mem.data_wdata.key     = f_data_reg.key;
                mem.data_wdata.use_cnt = use_new_reg;
                mem.data_wdata.expiry  = promote ? fresh_expiry : f_data_reg.expiry;
                pend_next.status       = ST_HIT;
                lt_s_next              = f_s_reg;
                if (promote)
                begin
                    pend_next.level = LEVEL_W'(dest_q);
                    mode_next       = M_PROMO;
                    mr_q_next       = dest_q;
                    lt_q_next       = dest_q;
                    state_next      = S_MR_CHK;
                end
                else
                begin
                    pend_next.level = LEVEL_W'(f_q_reg);
                    mode_next       = M_STAY;
                    lt_q_next       = f_q_reg;
                    state_next      = S_LINK;
                end
            end

            // Evict the head of a full queue before appending to it.
            S_MR_CHK:
            begin
                mem.raddr = head_reg[mr_q_reg];
                if (cnt_reg[mr_q_reg] != '0 && cnt_reg[mr_q_reg] >= eff_limit)
                begin
                    state_next = S_MR_POP;
                end
                else
                begin
                    state_next = (mode_reg == M_INS) ? S_FS_SCAN : S_LINK;
                end
            end

            S_MR_POP:
            begin
                head_next[mr_q_reg] = link_rd;
                cnt_next[mr_q_reg]  = cnt_reg[mr_q_reg] - CNT_W'(1);
                free_next[head_reg[mr_q_reg]] = 1'b1;
                em_next.status = ST_EVICTED;
                em_next.key    = data_rd.key;
                em_next.level  = LEVEL_W'(mr_q_reg);
                em_next.last   = 1'b0;
                state_next     = S_EMIT;
            end

            // The held result goes out as a non-final one; the new one waits.
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_next.last  = 1'b0;
                    out_valid_next = 1'b1;
                    pend_next      = em_reg;
                    state_next     = (mode_reg == M_INS) ? S_FS_SCAN : S_LINK;
                end
            end

            S_FS_SCAN:
            begin
                if (free_reg[fs_idx_reg])
                begin
                    free_next[fs_idx_reg]  = 1'b0;
                    mem.data_we            = 1'b1;
                    mem.data_waddr         = fs_idx_reg;
                    mem.data_wdata.key     = key_reg;
                    mem.data_wdata.use_cnt = USE_W'(1);
                    mem.data_wdata.expiry  = fresh_expiry;
                    lt_q_next              = '0;
                    lt_s_next              = fs_idx_reg;
                    state_next             = S_LINK;
                end
                else if (int'(fs_idx_reg) == NUM_SLOTS - 1)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    fs_idx_next = fs_idx_reg + SLOT_W'(1);
                end
            end

            S_LINK:
            begin
                if (cnt_reg[lt_q_reg] == '0)
                begin
                    head_next[lt_q_reg] = lt_s_reg;
                end
                else
                begin
                    mem.link_we    = 1'b1;
                    mem.link_waddr = tail_reg[lt_q_reg];
                    mem.link_wdata = lt_s_reg;
                end
                tail_next[lt_q_reg] = lt_s_reg;
                cnt_next[lt_q_reg]  = cnt_reg[lt_q_reg] + CNT_W'(1);
                case (mode_reg)
                    M_PROMO:
                    begin
                        state_next = S_AG_START;
                    end
                    M_AGE:
                    begin
                        ag_i_next  = ag_i_reg + QCNT_W'(1);
                        state_next = S_AG_RD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_AG_START:
            begin
                now_next   = now_reg + TIME_W'(1);
                ag_i_next  = QCNT_W'(1);
                state_next = S_AG_RD;
            end

            S_AG_RD:
            begin
                if (int'(ag_i_reg) >= NUM_QUEUES)
                begin
                    state_next = S_FINISH;
                end
                else if (cnt_reg[ag_qi] == '0)
                begin
                    ag_i_next = ag_i_reg + QCNT_W'(1);
                end
                else
                begin
                    mem.raddr  = head_reg[ag_qi];
                    state_next = S_AG_CHK;
                end
            end

            // An expired head drops to the tail of the queue below.
            S_AG_CHK:
            begin
                if (data_rd.expiry < now_reg)
                begin
                    lt_s_next        = head_reg[ag_qi];
                    head_next[ag_qi] = link_rd;
                    cnt_next[ag_qi]  = cnt_reg[ag_qi] - CNT_W'(1);
                    mr_q_next        = ag_qi - QIDX_W'(1);
                    lt_q_next        = ag_qi - QIDX_W'(1);
                    mode_next        = M_AGE;
                    state_next       = S_MR_CHK;
                end
                else
                begin
                    ag_i_next  = ag_i_reg + QCNT_W'(1);
                    state_next = S_AG_RD;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_INS;
            op_reg         <= 1'b0;
            key_reg        <= '0;
            lk_q_reg       <= '0;
            lk_s_reg       <= '0;
            lk_prev_reg    <= '0;
            lk_k_reg       <= '0;
            lk_hasprev_reg <= 1'b0;
            found_reg      <= 1'b0;
            f_q_reg        <= '0;
            f_s_reg        <= '0;
            f_prev_reg     <= '0;
            f_hasprev_reg  <= 1'b0;
            f_link_reg     <= '0;
            f_data_reg     <= '0;
            use_new_reg    <= '0;
            mr_q_reg       <= '0;
            lt_q_reg       <= '0;
            lt_s_reg       <= '0;
            ag_i_reg       <= '0;
            fs_idx_reg     <= '0;
            pend_reg       <= '0;
            em_reg         <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            free_reg       <= '1;
            now_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            lk_q_reg       <= lk_q_next;
            lk_s_reg       <= lk_s_next;
            lk_prev_reg    <= lk_prev_next;
            lk_k_reg       <= lk_k_next;
            lk_hasprev_reg <= lk_hasprev_next;
            found_reg      <= found_next;
            f_q_reg        <= f_q_next;
            f_s_reg        <= f_s_next;
            f_prev_reg     <= f_prev_next;
            f_hasprev_reg  <= f_hasprev_next;
            f_link_reg     <= f_link_next;
            f_data_reg     <= f_data_next;
            use_new_reg    <= use_new_next;
            mr_q_reg       <= mr_q_next;
            lt_q_reg       <= lt_q_next;
            lt_s_reg       <= lt_s_next;
            ag_i_reg       <= ag_i_next;
            fs_idx_reg     <= fs_idx_next;
            pend_reg       <= pend_next;
            em_reg         <= em_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
            free_reg       <= free_next;
            now_reg        <= now_next;
        end
    end
endmodule

`default_nettype wire

[rtl/core/multi_queue_replacement_policy.sv]
// Multi-queue cache replacement policy over 32-bit key tags. Keys live in
// NUM_QUEUES LRU queues kept as linked lists in two slot memories (one for
// key, use count and expiry, one for the next-slot links), each with a
// registered read. A request transaction either inserts a key at the tail of
// queue 0 or accesses one; a hit bumps the use count and, once the count
// exceeds 2^level, promotes the key one queue up, advances time by one tick
// and lets each expired upper head drop one queue. Every request returns its
// own result first (hit, miss, inserted or duplicate), followed by one result
// transaction per eviction; the final one carries last = 1. The lookup walks
// the queues entry by entry, one memory read and one compare per entry; the
// update follows, with a free-slot scan on insert, an eviction for each full
// queue and a drop for each expired head. The block works on one request at a
// time; the result register lets the next request enter while the last
// result still waits. Configuration writes are always accepted and should be
// made only while the block is idle. No clearing pass is needed after reset.
// Depends on mq_pkg, the channel interfaces, mq_ram and mq_engine.
`default_nettype none

module multi_queue_replacement_policy
    import mq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mq_req_if.sink    req,
    mq_res_if.source  res,
    mq_cfg_if.sink    cfg
);
    logic [LIFE_W-1:0]  lifetime_reg;
    logic [LIMIT_W-1:0] queue_limit_reg;
    cfg_t               cfg_val;
    mem_req_t           mem;
    slot_data_t         data_rd;
    logic [DATA_W-1:0]  data_rd_raw;
    logic [SLOT_W-1:0]  link_rd;

    // Configuration registers take every write transaction.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg    <= LIFETIME_RESET;
            queue_limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                CFG_LIFETIME:
                begin
                    lifetime_reg <= cfg.wdata;
                end
                CFG_QUEUE_LIMIT:
                begin
                    queue_limit_reg <= cfg.wdata[LIMIT_W-1:0];
                end
                default:
                begin
                    lifetime_reg <= lifetime_reg;
                end
            endcase
        end
    end

    assign cfg_val.lifetime    = lifetime_reg;
    assign cfg_val.queue_limit = queue_limit_reg;
    assign data_rd             = slot_data_t'(data_rd_raw);

    // Slot payload memory: key, use count and expiry.
    mq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (mem.data_we),
        .waddr (mem.data_waddr),
        .wdata (mem.data_wdata),
        .raddr (mem.raddr),
        .rdata (data_rd_raw)
    );

    // Slot link memory: the next slot in the same queue.
    mq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem.link_we),
        .waddr (mem.link_waddr),
        .wdata (mem.link_wdata),
        .raddr (mem.raddr),
        .rdata (link_rd)
    );

    mq_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .cfg     (cfg_val),
        .mem     (mem),
        .data_rd (data_rd),
        .link_rd (link_rd)
    );
endmodule

`default_nettype wire

[bench/mq_checker.sv]
// Checker for the multi-queue replacement policy: watches the request,
// result and configuration channels, predicts results and compares them.
// Depends on mq_pkg and the channel interfaces.
`timescale 1ns / 1ps

module mq_checker
    import mq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mq_req_if           req,
    mq_res_if           res,
    mq_cfg_if           cfg,
    output int          errors,
    output int          pending
);

    localparam int NO_SLOT = NUM_SLOTS;

    logic [KEY_W-1:0]   s_key    [NUM_SLOTS];
    int unsigned        s_use    [NUM_SLOTS];
    logic [TIME_W-1:0]  s_exp    [NUM_SLOTS];
    int                 s_link   [NUM_SLOTS];
    bit                 s_free   [NUM_SLOTS];
    int                 q_head   [NUM_QUEUES];
    int                 q_tail   [NUM_QUEUES];
    int                 q_cnt    [NUM_QUEUES];
    logic [TIME_W-1:0]  ticks;
    logic [LIFE_W-1:0]  life;
    logic [LIMIT_W-1:0] limit;
    result_t            expected_results[$];
    result_t            batch[$];

    assign pending = expected_results.size();

    function automatic int eff_limit();
        int l;
        l = limit;
        if (l == 0) l = 1;
        if (l > QUEUE_DEPTH) l = QUEUE_DEPTH;
        return l;
    endfunction

    function automatic int pop_head(int q);
        int h;
        h = q_head[q];
        q_head[q] = s_link[h];
        q_cnt[q]--;
        return h;
    endfunction

    function automatic void push_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
                                        int lvl);
        result_t r;
        r.status = st;
        r.key    = k;
        r.level  = lvl[LEVEL_W-1:0];
        r.last   = 1'b0;
        batch.push_back(r);
    endfunction

    function automatic void evict_if_full(int q);
        int h;
        if (q_cnt[q] > 0 && q_cnt[q] >= eff_limit()) begin
            h = pop_head(q);
            s_free[h] = 1'b1;
            push_result(ST_EVICTED, s_key[h], q);
        end
    endfunction

    function automatic void append(int q, int s);
        if (q_cnt[q] == 0) q_head[q] = s;
        else s_link[q_tail[q]] = s;
        q_tail[q] = s;
        q_cnt[q]++;
    endfunction

    function automatic void predict_request(logic op, logic [KEY_W-1:0] k);
        int q, s, prev, fq, fs, fprev, fs_free, dest, h;
        bit found, has_prev;
        logic [STATUS_W-1:0] st;
        int lvl;
        found = 1'b0;
        fq = 0; fs = 0; fprev = 0; has_prev = 1'b0; lvl = 0;
        batch.delete();
        push_result(ST_MISS, k, 0);
        for (q = 0; q < NUM_QUEUES && !found; q++) begin
            s = q_head[q];
            prev = 0;
            for (int n = 0; n < q_cnt[q] && !found; n++) begin
                if (s_key[s] == k) begin
                    found = 1'b1; fq = q; fs = s; fprev = prev; has_prev = (n != 0);
                end else begin
                    prev = s;
                    s = s_link[s];
                end
            end
        end
        if (op == OP_INSERT) begin
            if (found) begin
                st = ST_DUP;
                lvl = fq;
            end else begin
                evict_if_full(0);
                fs_free = NO_SLOT;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (fs_free == NO_SLOT && s_free[i]) fs_free = i;
                if (fs_free != NO_SLOT) begin
                    s_free[fs_free] = 1'b0;
                    s_key[fs_free] = k;
                    s_use[fs_free] = 1;
                    s_exp[fs_free] = ticks + TIME_W'(life);
                    append(0, fs_free);
                end
                st = ST_INSERTED;
            end
        end else if (!found) begin
            st = ST_MISS;
        end else begin
            st = ST_HIT;
            // Unlink the hit entry from its queue.
            if (!has_prev) q_head[fq] = s_link[fs];
            else s_link[fprev] = s_link[fs];
            if (q_tail[fq] == fs && has_prev) q_tail[fq] = fprev;
            q_cnt[fq]--;
            if (s_use[fs] < 65535) s_use[fs]++;
            if (s_use[fs] > (1 << fq)) begin
                dest = (fq + 1 < NUM_QUEUES) ? fq + 1 : fq;
                s_exp[fs] = ticks + TIME_W'(life);
                evict_if_full(dest);
                append(dest, fs);
                lvl = dest;
                ticks = ticks + 1;
                for (int i = 1; i < NUM_QUEUES; i++) begin
                    if (q_cnt[i] > 0 && s_exp[q_head[i]] < ticks) begin
                        h = pop_head(i);
                        evict_if_full(i - 1);
                        append(i - 1, h);
                    end
                end
            end else begin
                append(fq, fs);
                lvl = fq;
            end
        end
        batch[0].status = st;
        batch[0].level = lvl[LEVEL_W-1:0];
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_results.push_back(batch[i]);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t e;
        if (!rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) s_free[i] = 1'b1;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                q_head[i] = 0; q_tail[i] = 0; q_cnt[i] = 0;
            end
            ticks = '0;
            life = LIFETIME_RESET;
            limit = LIMIT_RESET;
            expected_results.delete();
            errors = 0;
        end else begin
            // Results are checked before the request of the same edge is predicted.
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: status %0d key %h",
                           res.status, res.res_key);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (res.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, res.status);
                        errors++;
                    end
                    if (res.res_key !== e.key) begin
                        $error("res_key: expected %h, actual %h", e.key, res.res_key);
                        errors++;
                    end
                    if (res.level !== e.level) begin
                        $error("level: expected %0d, actual %0d", e.level, res.level);
                        errors++;
                    end
                    if (res.last !== e.last) begin
                        $error("last: expected %0d, actual %0d", e.last, res.last);
                        errors++;
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                if (cfg.reg_index == CFG_LIFETIME) life = cfg.wdata[LIFE_W-1:0];
                else limit = cfg.wdata[LIMIT_W-1:0];
            end
            if (req.valid && req.ready) predict_request(req.opcode, req.req_key);
        end
    end

endmodule

[bench/tb_multi_queue_replacement_policy.sv]
// Top of the multi-queue replacement policy testbench: clock, reset,
// request and configuration stimulus, result back-pressure and verdict.
// Depends on mq_pkg, the channel interfaces, the block and mq_checker.
`timescale 1ns / 1ps

module tb_multi_queue_replacement_policy;
    import mq_pkg::*;

    // Slowest request: a full lookup walk, a slot scan and several evictions,
    // each result possibly held up by a stall of the result side. The limit
    // below takes that many times over for every request of the run.
    localparam int CYCLE_LIMIT = 400 * 2000;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   res_stall_on;

    mq_req_if req ();
    mq_res_if res ();
    mq_cfg_if cfg ();

    multi_queue_replacement_policy DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    mq_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    // Keys the run has inserted, so that most accesses find something.
    logic [KEY_W-1:0] known_keys[$];

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: a hang in the block ends the run as a failure.
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The result side stalls in random bursts while res_stall_on is set.
    always @(posedge clk or negedge rst_n) begin
        int burst;
        if (!rst_n) begin
            res.ready <= 1'b0;
            burst = 0;
        end else if (burst > 0) begin
            burst--;
            res.ready <= 1'b0;
        end else if (res_stall_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 18) - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    // One request transaction; valid stays high until accepted. Valid is left
    // high afterwards so that the next request can follow at once; an idle
    // gap or wait_drained() takes it low.
    task automatic send_request(logic op, logic [KEY_W-1:0] k, bit gaps);
        if (gaps && $urandom_range(0, 4) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.opcode  <= op;
        req.req_key <= k;
        do @(posedge clk); while (!req.ready);
        if (op == OP_INSERT) known_keys.push_back(k);
    endtask

    // Stops the request stream, waits until every expected result transaction
    // has been seen, then lets the block settle before any register is touched.
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wdata     <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(0, 9) < 8)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return {$urandom_range(0, 15) == 0 ? $urandom() : {28'h0, 4'($urandom())}};
    endfunction

    // A random phase: mostly accesses of held keys, so that promotions,
    // aging and evictions happen, plus fresh inserts and some noise.
    task automatic random_phase(int count, bit gaps);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                k = ($urandom_range(0, 3) == 0) ? $urandom() : {24'h0, 8'($urandom())};
                send_request(OP_INSERT, k, gaps);
            end else begin
                send_request(OP_ACCESS, pick_key(), gaps);
            end
        end
    endtask

    initial begin
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.opcode    <= OP_ACCESS;
        req.req_key   <= '0;
        cfg.valid     <= 1'b0;
        cfg.reg_index <= CFG_LIFETIME;
        cfg.wdata     <= '0;
        res_stall_on  = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: key extremes, miss, duplicate, hits and promotions under
        // the reset settings.
        send_request(OP_ACCESS, 32'h0000_0000, 1'b0);
        send_request(OP_INSERT, 32'h0000_0000, 1'b0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_INSERT, 32'hA5A5_5A5A, 1'b0);
        send_request(OP_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_ACCESS, 32'h0000_0000, 1'b0);
        send_request(OP_ACCESS, 32'h0000_0000, 1'b0);
        send_request(OP_ACCESS, 32'h1234_5678, 1'b0);
        wait_drained();

        // A limit of zero acts as one: every insert evicts the previous key.
        write_reg(CFG_QUEUE_LIMIT, 16'd0);
        write_reg(CFG_LIFETIME, 16'd1);
        for (int i = 0; i < 4; i++) send_request(OP_INSERT, 32'h100 + i, 1'b0);
        wait_drained();

        // Small queues and short lifetime: promotions push keys down fast.
        write_reg(CFG_QUEUE_LIMIT, 16'd3);
        random_phase(80, 1'b1);
        wait_drained();

        // Maximum lifetime and a limit above the queue depth.
        write_reg(CFG_LIFETIME, 16'hFFFF);
        write_reg(CFG_QUEUE_LIMIT, 16'h001F);
        random_phase(80, 1'b1);
        wait_drained();

        // Lower the limit under full queues: one head goes per append.
        write_reg(CFG_QUEUE_LIMIT, 16'd2);
        write_reg(CFG_LIFETIME, 16'd3);
        random_phase(80, 1'b1);
        wait_drained();

        // Back to the reset values; the last part runs without idling.
        write_reg(CFG_QUEUE_LIMIT, 16'd16);
        write_reg(CFG_LIFETIME, 16'd5);
        random_phase(30, 1'b1);
        res_stall_on = 1'b0;
        random_phase(40, 1'b0);

        wait_drained();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
